>>> design/voxhist_pkg.sv
// Shared types and fixed field widths for the voxel occupancy histogram.
`timescale 1ns / 1ps
`default_nettype none

package voxhist_pkg;

    localparam int COORD_BITS  = 8;
    localparam int OUT_CNT_W   = 16;
    localparam int OUT_TOTAL_W = 17;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 56;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD
    } t_back_state;

endpackage

`default_nettype wire

>>> design/voxhist_front.sv
// Front end: offsets coordinates, checks bounds and forms the linear voxel index.
`timescale 1ns / 1ps
`default_nettype none

module voxhist_front #(
    parameter int GRID_XY = 31,
    parameter int GRID_Z  = 7,
    parameter int IW      = 13
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic [voxhist_pkg::COORD_BITS-1:0]   i_coord_i,
    input  wire logic [voxhist_pkg::COORD_BITS-1:0]   i_coord_j,
    input  wire logic [voxhist_pkg::COORD_BITS-1:0]   i_coord_k,
    input  wire logic                                 i_occupied,
    output logic                                      o_q_valid,
    input  wire logic                                 i_q_ready,
    output logic                                      o_q_inside,
    output logic                                      o_q_occ,
    output logic [IW-1:0]                             o_q_idx
);
    import voxhist_pkg::*;

    localparam int XYN = GRID_XY * GRID_XY;
    localparam int XYW = (XYN > 1) ? $clog2(XYN) : 1;
    localparam int SW  = COORD_BITS + 2;

    logic signed [SW-1:0] x_s, y_s, z_s;
    logic                 in_grid;
    logic                 en;

    logic                  r_v1, r_inside1, r_occ1;
    logic [COORD_BITS-1:0] r_x1, r_y1, r_z1;
    logic                  r_v2, r_inside2, r_occ2;
    logic [XYW-1:0]        r_xy2;
    logic [COORD_BITS-1:0] r_z2;

    // offset coordinates: sign extend, then add the integer half of the grid
    assign x_s = $signed({{2{i_coord_i[COORD_BITS-1]}}, i_coord_i}) + SW'(GRID_XY / 2);
    assign y_s = $signed({{2{i_coord_j[COORD_BITS-1]}}, i_coord_j}) + SW'(GRID_XY / 2);
    assign z_s = $signed({{2{i_coord_k[COORD_BITS-1]}}, i_coord_k}) + SW'(GRID_Z / 2);

    assign in_grid = !x_s[SW-1] && (x_s[SW-2:0] < (SW-1)'(GRID_XY)) &&
                     !y_s[SW-1] && (y_s[SW-2:0] < (SW-1)'(GRID_XY)) &&
                     !z_s[SW-1] && (z_s[SW-2:0] < (SW-1)'(GRID_Z));

    assign en      = !r_v2 || i_q_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_inside1 <= in_grid;
            r_occ1    <= i_occupied;
            r_x1      <= x_s[COORD_BITS-1:0];
            r_y1      <= y_s[COORD_BITS-1:0];
            r_z1      <= z_s[COORD_BITS-1:0];
            r_inside2 <= r_inside1;
            r_occ2    <= r_occ1;
            r_xy2     <= XYW'(32'(r_x1) * GRID_XY + 32'(r_y1));
            r_z2      <= r_z1;
        end
    end

    assign o_q_valid  = r_v2;
    assign o_q_inside = r_inside2;
    assign o_q_occ    = r_occ2;
    assign o_q_idx    = IW'(32'(r_xy2) * GRID_Z + 32'(r_z2));

endmodule

`default_nettype wire

>>> design/voxhist_queue.sv
// Two-entry first-word-fall-through queue between the front and the back end.
`timescale 1ns / 1ps
`default_nettype none

module voxhist_queue #(
    parameter int W = 15
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_wr_valid,
    output logic              o_wr_ready,
    input  wire logic [W-1:0] i_wr_data,
    output logic              o_rd_valid,
    input  wire logic         i_rd_ready,
    output logic [W-1:0]      o_rd_data
);
    import voxhist_pkg::*;

    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         push, pop;

    assign o_wr_ready = (r_cnt != 2'd2);
    assign o_rd_valid = (r_cnt != 2'd0);
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;
    assign o_rd_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_wr_data;
    end

endmodule

`default_nettype wire

>>> design/voxhist_back.sv
// Back end: count memory with clearing sweep and saturating read-modify-write.
`timescale 1ns / 1ps
`default_nettype none

module voxhist_back #(
    parameter int NV         = 6727,
    parameter int IW         = 13,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_q_valid,
    output logic                                       o_q_ready,
    input  wire logic                                  i_q_inside,
    input  wire logic                                  i_q_occ,
    input  wire logic [IW-1:0]                         i_q_idx,
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic                                       o_in_range,
    output logic [voxhist_pkg::OUT_CNT_W-1:0]          o_count_occupied,
    output logic [voxhist_pkg::OUT_CNT_W-1:0]          o_count_free,
    output logic [voxhist_pkg::OUT_TOTAL_W-1:0]        o_count_total
);
    import voxhist_pkg::*;

    localparam int CB = COUNT_BITS;

    // each entry: free count in the high half, occupied count in the low half
    logic [2*CB-1:0] r_mem [NV];
    logic [2*CB-1:0] r_rd_data;

    t_back_state r_state, n_state;
    logic [IW-1:0] r_clr_addr;
    logic [IW-1:0] r_idx;
    logic          r_occ;

    logic          r_out_valid, r_out_inside;
    logic [CB-1:0] r_out_occ, r_out_free;

    logic          out_free, q_pop, rd_en, wr_en, load_out, clr_last;
    logic [IW-1:0] wr_addr;
    logic [2*CB-1:0] wr_data;
    logic [CB-1:0] cur_occ, cur_free, new_occ, new_free;

    assign out_free = !r_out_valid || i_ready;
    assign clr_last = (r_clr_addr == IW'(NV - 1));
    assign cur_occ  = r_rd_data[CB-1:0];
    assign cur_free = r_rd_data[2*CB-1:CB];
    assign new_occ  = (r_occ && cur_occ != '1)   ? cur_occ + 1'b1  : cur_occ;
    assign new_free = (!r_occ && cur_free != '1) ? cur_free + 1'b1 : cur_free;

    always_comb begin
        n_state  = r_state;
        q_pop    = 1'b0;
        rd_en    = 1'b0;
        wr_en    = 1'b0;
        load_out = 1'b0;
        wr_addr  = r_idx;
        wr_data  = {new_free, new_occ};
        unique case (r_state)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr_addr;
                wr_data = '0;
                if (clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_inside) begin
                        q_pop   = 1'b1;
                        rd_en   = 1'b1;
                        n_state = ST_UPD;
                    end else if (out_free) begin
                        q_pop    = 1'b1;
                        load_out = 1'b1;
                    end
                end
            end
            ST_UPD: begin
                if (out_free) begin
                    wr_en    = 1'b1;
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    assign o_q_ready = q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr_addr <= r_clr_addr + 1'b1;
            if (load_out)     r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_pop) begin
            r_idx <= i_q_idx;
            r_occ <= i_q_occ;
        end
        if (load_out) begin
            r_out_inside <= (r_state == ST_UPD);
            r_out_occ    <= (r_state == ST_UPD) ? new_occ  : '0;
            r_out_free   <= (r_state == ST_UPD) ? new_free : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) r_rd_data <= r_mem[i_q_idx];
    end

    logic [32:0] occ_ext, free_ext;
    logic [33:0] total_ext;

    assign occ_ext   = {{(33-CB){1'b0}}, r_out_occ};
    assign free_ext  = {{(33-CB){1'b0}}, r_out_free};
    assign total_ext = {1'b0, occ_ext} + {1'b0, free_ext};

    assign o_valid          = r_out_valid;
    assign o_in_range       = r_out_inside;
    assign o_count_occupied = occ_ext[OUT_CNT_W-1:0];
    assign o_count_free     = free_ext[OUT_CNT_W-1:0];
    assign o_count_total    = total_ext[OUT_TOTAL_W-1:0];

    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !q_pop)
        else $error("queue popped during clearing sweep");

    a_wr_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (32'(wr_addr) < NV))
        else $error("count memory write out of range");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_inside) |-> (r_out_occ == '0 && r_out_free == '0))
        else $error("out-of-range result carries nonzero counts");

    a_upd_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD && out_free) |=> (r_out_valid && r_out_inside))
        else $error("update did not produce an in-range result");

endmodule

`default_nettype wire

>>> design/voxel_occupancy_histogram_unit.sv
// Top level of the voxel occupancy histogram: front end, queue and count back end.
// An in-range item passes the front-end registers, the queue and the back end's
// idle (read) and update (write) states before it shows on the master side; an
// out-of-range item goes to the output from the idle state with no memory access.
// The back end takes no new item until it has written back the last in-range one.
// Reset: synchronous; afterwards the back end zeroes GRID_XY*GRID_XY*GRID_Z entries
// (6727 by default), one per cycle, before results flow.
`timescale 1ns / 1ps
`default_nettype none

module voxel_occupancy_histogram_unit #(
    parameter int GRID_XY    = 31,
    parameter int GRID_Z     = 7,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // coord_i [7:0], coord_j [15:8], coord_k [23:16]
    input  wire logic [voxhist_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // occupied
    input  wire logic                                 s_axis_tuser,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // count_occupied [15:0], count_free [31:16], count_total [48:32], zero pad
    output logic [voxhist_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    // in_range
    output logic                                      m_axis_tuser
);
    import voxhist_pkg::*;

    localparam int NV = GRID_XY * GRID_XY * GRID_Z;
    localparam int IW = (NV > 1) ? $clog2(NV) : 1;
    localparam int QW = IW + 2;

    logic          f_valid, f_ready, f_inside, f_occ;
    logic [IW-1:0] f_idx;
    logic          q_valid, q_ready;
    logic [QW-1:0] q_data;

    logic                   b_in_range;
    logic [OUT_CNT_W-1:0]   b_occ, b_free;
    logic [OUT_TOTAL_W-1:0] b_total;

    voxhist_front #(
        .GRID_XY (GRID_XY),
        .GRID_Z  (GRID_Z),
        .IW      (IW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_coord_i  (s_axis_tdata[7:0]),
        .i_coord_j  (s_axis_tdata[15:8]),
        .i_coord_k  (s_axis_tdata[23:16]),
        .i_occupied (s_axis_tuser),
        .o_q_valid  (f_valid),
        .i_q_ready  (f_ready),
        .o_q_inside (f_inside),
        .o_q_occ    (f_occ),
        .o_q_idx    (f_idx)
    );

    voxhist_queue #(
        .W (QW)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (f_valid),
        .o_wr_ready (f_ready),
        .i_wr_data  ({f_inside, f_occ, f_idx}),
        .o_rd_valid (q_valid),
        .i_rd_ready (q_ready),
        .o_rd_data  (q_data)
    );

    voxhist_back #(
        .NV         (NV),
        .IW         (IW),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .o_q_ready        (q_ready),
        .i_q_inside       (q_data[QW-1]),
        .i_q_occ          (q_data[QW-2]),
        .i_q_idx          (q_data[IW-1:0]),
        .o_valid          (m_axis_tvalid),
        .i_ready          (m_axis_tready),
        .o_in_range       (b_in_range),
        .o_count_occupied (b_occ),
        .o_count_free     (b_free),
        .o_count_total    (b_total)
    );

    assign m_axis_tuser = b_in_range;
    assign m_axis_tdata = {{(OUT_TDATA_W - 2*OUT_CNT_W - OUT_TOTAL_W){1'b0}},
                           b_total, b_free, b_occ};

endmodule

`default_nettype wire
